[rtl/core/skat_pkg.sv]
`timescale 1ns / 1ps
// skat_pkg: shared constants, item types and divider control types
// for the scalar angle tracker; no dependencies
package skat_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);

	// gain divider sizing
	localparam int GAIN_STEPS = 17;
	localparam int DEN_W = 17;
	localparam int NUM_W = GAIN_STEPS;
	localparam int STEP_W = $clog2(GAIN_STEPS + 1);

	// rate-times-time divide by the tick rate, one 16-bit digit at a time
	localparam int RATE_W = 48;
	localparam int CHUNK_W = 16;
	localparam int RATE_CHUNKS = RATE_W / CHUNK_W;
	localparam int CHUNK_CNT_W = $clog2(RATE_CHUNKS);
	localparam logic [CHUNK_CNT_W-1:0] CHUNK_LAST = CHUNK_CNT_W'(RATE_CHUNKS - 1);
	localparam int REM_T_W = TICK_W + CHUNK_W;
	localparam int RECIP_SHIFT = 2 * TICK_W + CHUNK_W;
	localparam int RECIP_W = TICK_W + 17;
	localparam longint RECIP_FULL = ((longint'(1) <<< RECIP_SHIFT)
		+ longint'(TICKS_PER_SECOND) - longint'(1)) / longint'(TICKS_PER_SECOND);
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);
	localparam logic [RATE_W-1:0] RATE_HALF = RATE_W'(TICKS_PER_SECOND / 2);

	// configuration registers
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;
	localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET = 16'd164;
	localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RESET = 16'd5898;

	// mode codes
	localparam logic [2:0] MODE_ZERO_A = 3'd1;
	localparam logic [2:0] MODE_ZERO_B = 3'd2;
	localparam logic [2:0] MODE_MEASURED = 3'd3;
	localparam logic [2:0] MODE_COMMANDED = 3'd4;

	typedef struct packed {
		logic signed [31:0] angle_meas;
		logic signed [31:0] rate_measured;
		logic signed [31:0] rate_commanded;
		logic [2:0] mode;
		logic [15:0] elapsed_ms;
	} meas_item_t;

	typedef struct packed {
		logic signed [31:0] estimate;
		logic [15:0] gain;
		logic [15:0] variance;
	} est_item_t;

	typedef struct packed {
		logic start;
		logic [STEP_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic last;
	} div_stat_t;

endpackage

[rtl/core/skat_div.sv]
`timescale 1ns / 1ps
// skat_div: restoring bit-serial divider, one quotient bit per cycle
// depends on skat_pkg
module skat_div import skat_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_cmd_t cmd,
	input logic [DEN_W-1:0] rem_init,
	input logic [NUM_W-1:0] num_init,
	input logic [DEN_W-1:0] divisor,
	output div_stat_t stat,
	output logic [NUM_W-1:0] quot
);

	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] n_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] trial_sub;
	logic fits;

	assign trial = {rem_q, n_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= cmd.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= rem_init;
			n_q <= num_init;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			n_q <= {n_q[NUM_W-2:0], fits};
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.last = cnt_q == STEP_W'(1);
	assign quot = n_q;

endmodule

[rtl/core/scalar_kalman_angle_tracker_top.sv]
`timescale 1ns / 1ps
// scalar_kalman_angle_tracker_top: one-dimensional kalman filter on an angle
// depends on skat_pkg and skat_div
//
// Usage: measurement items enter on meas_valid/meas_stall/meas_item, one
// filtered result per item leaves on est_valid/est_stall/est_item. An item
// is taken on a rising edge with valid high and stall low.
// The first item after reset only seeds the estimate: its result carries
// gain and variance zero, and the sequencer goes through S_FINISH straight
// back to idle.
// For every later item the rate-times-time product is divided by the tick
// rate in three 16-bit digits on the shared multiplier (reciprocal
// multiply, then remainder), the serial divider works out the gain, and
// eight sequencer steps handle the products, prediction, correction and
// output.
// meas_stall is high while an item is in work. A finished result sits in
// the output register; a new item is taken while it waits, and a further
// result is held back until est_stall drops.
// cfg_we writes process noise (index 0) or measurement noise (index 1);
// the user must write only while idle; the block does not enforce it. Reset
// clears the filter state, restores default noise values and drops est_valid.
module scalar_kalman_angle_tracker_top import skat_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic meas_valid,
	output logic meas_stall,
	input meas_item_t meas_item,
	output logic est_valid,
	input logic est_stall,
	output est_item_t est_item,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [11:0] {
		S_IDLE      = 12'b000000000001,
		S_MUL_RATE  = 12'b000000000010,
		S_LOAD_RATE = 12'b000000000100,
		S_RECIP_MUL = 12'b000000001000,
		S_RECIP_SUB = 12'b000000010000,
		S_PRED      = 12'b000000100000,
		S_DIV_GAIN  = 12'b000001000000,
		S_GAIN      = 12'b000010000000,
		S_MUL_VAR   = 12'b000100000000,
		S_MUL_CORR  = 12'b001000000000,
		S_CORR      = 12'b010000000000,
		S_FINISH    = 12'b100000000000
	} state_t;

	state_t state_q;
	logic started_q;
	logic primed_q;
	logic signed [31:0] est_q;
	logic [15:0] var_q;
	logic signed [31:0] rate_q;
	logic signed [31:0] pend_q;
	logic [CFG_W-1:0] q_noise_q;
	logic [CFG_W-1:0] r_noise_q;
	logic est_valid_q;
	est_item_t est_item_q;

	logic signed [31:0] meas_q;
	logic [15:0] elapsed_q;
	logic neg_q;
	logic [15:0] p_q;
	logic den_zero_q;
	logic [15:0] k_q;
	logic signed [32:0] diff_q;
	logic signed [51:0] prod_q;
	logic [RATE_W-1:0] rnum_q;
	logic [RATE_W-1:0] rquo_q;
	logic [TICK_W-1:0] rrem_q;
	logic [CHUNK_CNT_W-1:0] chunk_q;

	logic meas_take;
	logic out_free;

	logic signed [33:0] mul_a;
	logic signed [RECIP_W:0] mul_b;
	logic signed [RECIP_W+34:0] mul_p;
	logic [16:0] inv_k;

	logic [51:0] rate_mag;
	logic [RATE_W-1:0] rate_num;
	logic [REM_T_W-1:0] rchunk_t;
	logic [CHUNK_W-1:0] rdig;
	logic [REM_T_W-1:0] rdig_back;
	logic [REM_T_W-1:0] rrem_next;
	logic [16:0] p_sum;
	logic [15:0] p_new;
	logic [16:0] den_new;

	div_cmd_t div_cmd;
	div_stat_t div_stat;
	logic [DEN_W-1:0] div_rem;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [NUM_W-1:0] div_quot;

	logic signed [52:0] delta;
	logic signed [52:0] est_pred;
	logic [51:0] corr_mag;
	logic [51:0] corr_rnd;
	logic signed [52:0] corr;
	logic signed [52:0] est_corr;
	logic [15:0] k_new;

	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		if (v > 53'sd2147483647) begin
			sat32 = 32'sh7FFFFFFF;
		end else if (v < -53'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	assign meas_take = meas_valid && !meas_stall;
	assign meas_stall = state_q != S_IDLE;
	assign out_free = !est_valid_q || !est_stall;

	// shared multiplier
	assign inv_k = 17'h10000 - {1'b0, k_q};
	assign rchunk_t = {rrem_q, rnum_q[RATE_W-1 -: CHUNK_W]};

	always_comb begin
		unique case (state_q)
			S_MUL_RATE: begin
				mul_a = {{2{rate_q[31]}}, rate_q};
				mul_b = {{(RECIP_W-15){1'b0}}, elapsed_q};
			end
			S_RECIP_MUL: begin
				mul_a = {{(34-REM_T_W){1'b0}}, rchunk_t};
				mul_b = {1'b0, RECIP_M};
			end
			S_MUL_VAR: begin
				mul_a = {18'd0, p_q};
				mul_b = {{(RECIP_W-16){1'b0}}, inv_k};
			end
			S_MUL_CORR: begin
				mul_a = {diff_q[32], diff_q};
				mul_b = {{(RECIP_W-15){1'b0}}, k_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// rate divide by the tick rate, one digit per multiply and subtract
	assign rate_mag = prod_q[51] ? 52'(-prod_q) : 52'(prod_q);
	assign rate_num = rate_mag[RATE_W-1:0] + RATE_HALF;
	assign rdig = prod_q[RECIP_SHIFT +: CHUNK_W];
	assign rdig_back = REM_T_W'(rdig) * REM_T_W'(TICKS_PER_SECOND);
	assign rrem_next = rchunk_t - rdig_back;

	// gain divider operands
	assign p_sum = {1'b0, var_q} + {1'b0, q_noise_q};
	assign p_new = p_sum[16] ? 16'hFFFF : p_sum[15:0];
	assign den_new = {1'b0, p_new} + {1'b0, r_noise_q};

	always_comb begin
		div_cmd.start = state_q == S_PRED;
		div_cmd.steps = STEP_W'(GAIN_STEPS);
		div_rem = DEN_W'(p_new[15:1]);
		div_num = {p_new[0], {(NUM_W-1){1'b0}}};
		div_den = DEN_W'(den_new);
	end

	skat_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(div_cmd),
		.rem_init(div_rem),
		.num_init(div_num),
		.divisor(div_den),
		.stat(div_stat),
		.quot(div_quot)
	);

	// prediction and correction arithmetic
	assign delta = neg_q ? -$signed({5'd0, rquo_q}) : $signed({5'd0, rquo_q});
	assign est_pred = {{21{est_q[31]}}, est_q} + delta;

	assign corr_mag = prod_q[51] ? 52'(-prod_q) : 52'(prod_q);
	assign corr_rnd = corr_mag + 52'd32768;
	assign corr = prod_q[51] ? -$signed({17'd0, corr_rnd[51:16]})
		: $signed({17'd0, corr_rnd[51:16]});
	assign est_corr = {{21{est_q[31]}}, est_q} + corr;

	assign k_new = den_zero_q ? 16'd0 : (div_quot[16] ? 16'hFFFF : div_quot[15:0]);

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			started_q <= 1'b0;
			primed_q <= 1'b0;
			est_q <= '0;
			var_q <= '0;
			rate_q <= '0;
			pend_q <= '0;
			q_noise_q <= PROCESS_NOISE_RESET;
			r_noise_q <= MEASUREMENT_NOISE_RESET;
			est_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PROCESS_NOISE) begin
					q_noise_q <= cfg_data;
				end else if (cfg_index == REG_MEASUREMENT_NOISE) begin
					r_noise_q <= cfg_data;
				end
			end
			if (state_q == S_FINISH && out_free) begin
				est_valid_q <= 1'b1;
			end else if (est_valid_q && !est_stall) begin
				est_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (meas_take) begin
						if (!started_q) begin
							started_q <= 1'b1;
							est_q <= meas_item.angle_meas;
							var_q <= '0;
							rate_q <= '0;
							primed_q <= meas_item.mode == MODE_COMMANDED;
							if (meas_item.mode == MODE_COMMANDED) begin
								pend_q <= meas_item.rate_commanded;
							end
							state_q <= S_FINISH;
						end else begin
							if (meas_item.mode == MODE_ZERO_A || meas_item.mode == MODE_ZERO_B) begin
								rate_q <= '0;
								primed_q <= 1'b0;
							end else if (meas_item.mode == MODE_MEASURED) begin
								rate_q <= meas_item.rate_measured;
								primed_q <= 1'b0;
							end else if (meas_item.mode == MODE_COMMANDED) begin
								if (primed_q) begin
									rate_q <= pend_q;
								end
								pend_q <= meas_item.rate_commanded;
								primed_q <= 1'b1;
							end
							state_q <= S_MUL_RATE;
						end
					end
				end
				S_MUL_RATE: begin
					state_q <= S_LOAD_RATE;
				end
				S_LOAD_RATE: begin
					state_q <= S_RECIP_MUL;
				end
				S_RECIP_MUL: begin
					state_q <= S_RECIP_SUB;
				end
				S_RECIP_SUB: begin
					if (chunk_q == CHUNK_LAST) begin
						state_q <= S_PRED;
					end else begin
						state_q <= S_RECIP_MUL;
					end
				end
				S_PRED: begin
					est_q <= sat32(est_pred);
					state_q <= S_DIV_GAIN;
				end
				S_DIV_GAIN: begin
					if (div_stat.last) begin
						state_q <= S_GAIN;
					end
				end
				S_GAIN: begin
					state_q <= S_MUL_VAR;
				end
				S_MUL_VAR: begin
					state_q <= S_MUL_CORR;
				end
				S_MUL_CORR: begin
					var_q <= prod_q[31:16];
					state_q <= S_CORR;
				end
				S_CORR: begin
					est_q <= sat32(est_corr);
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (meas_take) begin
			meas_q <= meas_item.angle_meas;
			elapsed_q <= meas_item.elapsed_ms;
			if (!started_q) begin
				k_q <= '0;
			end
		end
		if (state_q == S_MUL_RATE || state_q == S_RECIP_MUL || state_q == S_MUL_VAR
			|| state_q == S_MUL_CORR) begin
			prod_q <= mul_p[51:0];
		end
		if (state_q == S_LOAD_RATE) begin
			neg_q <= prod_q[51];
			rnum_q <= rate_num;
			rrem_q <= '0;
			chunk_q <= '0;
		end
		if (state_q == S_RECIP_SUB) begin
			rquo_q <= {rquo_q[RATE_W-CHUNK_W-1:0], rdig};
			rnum_q <= {rnum_q[RATE_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
			rrem_q <= rrem_next[TICK_W-1:0];
			chunk_q <= chunk_q + CHUNK_CNT_W'(1);
		end
		if (state_q == S_PRED) begin
			p_q <= p_new;
			den_zero_q <= den_new == 17'd0;
		end
		if (state_q == S_GAIN) begin
			k_q <= k_new;
			diff_q <= {meas_q[31], meas_q} - {est_q[31], est_q};
		end
		if (state_q == S_FINISH && out_free) begin
			est_item_q.estimate <= est_q;
			est_item_q.gain <= k_q;
			est_item_q.variance <= var_q;
		end
	end

	assign est_valid = est_valid_q;
	assign est_item = est_item_q;

	// checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_div_last_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.last |-> state_q == S_DIV_GAIN)
		else $error("divider finishing outside a divide step");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		meas_take |=> state_q != S_IDLE)
		else $error("item taken but sequencer stayed idle");

	a_var_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CORR |-> var_q <= p_q)
		else $error("updated variance above predicted variance");

endmodule
